[hw/rtl/tsc_pkg.sv]
// tsc_pkg: shared constants and controller/datapath interface types
// for the text statistics counter. No dependencies.
`default_nettype none

package tsc_pkg;

   localparam int DEFAULT_COUNT_BITS = 16;
   localparam int FIELD_BITS         = 16;
   localparam int NUM_LETTERS        = 26;
   localparam int LETTER_BITS        = 5;
   localparam int BYTE_BITS          = 8;

   localparam logic [LETTER_BITS-1:0] LAST_LETTER = LETTER_BITS'(NUM_LETTERS - 1);

   localparam logic [BYTE_BITS-1:0] BYTE_PERIOD   = 8'd46;
   localparam logic [BYTE_BITS-1:0] BYTE_EXCLAIM  = 8'd33;
   localparam logic [BYTE_BITS-1:0] BYTE_QUESTION = 8'd63;
   localparam logic [BYTE_BITS-1:0] BYTE_SPACE    = 8'd32;
   localparam logic [BYTE_BITS-1:0] BYTE_UPPER_A  = 8'd65;
   localparam logic [BYTE_BITS-1:0] BYTE_UPPER_Z  = 8'd90;
   localparam logic [BYTE_BITS-1:0] BYTE_LOWER_A  = 8'd97;
   localparam logic [BYTE_BITS-1:0] BYTE_LOWER_Z  = 8'd122;

   // Controller to datapath.
   typedef struct packed {
      logic count;   // fold the accepted byte into the counters
      logic shift;   // a result beat left: move the histogram down one letter
      logic clear;   // last beat of the readout: zero all counts
   } tsc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic last_letter;
   } tsc_status_type;

endpackage

`default_nettype wire

[hw/rtl/tsc_ctrl.sv]
// tsc_ctrl: controller state machine of the text statistics counter.
// Depends on tsc_pkg for the command and status types.
`default_nettype none

module tsc_ctrl
   import tsc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_end_of_text,
   input  wire logic           rsp_stall,
   input  wire tsc_status_type status,
   output tsc_cmd_type         cmd,
   output logic                req_stall,
   output logic                rsp_valid
);

   typedef enum logic {
      ST_COUNT,
      ST_READOUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.count = req_valid && !req_stall_ff;
      cmd.shift = rsp_valid_ff && !rsp_stall;
      cmd.clear = cmd.shift && status.last_letter;
   end

   always_comb begin
      state_in     = state_ff;
      req_stall_in = req_stall_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_COUNT: begin
            // hold input off for the whole readout
            if (cmd.count && req_end_of_text) begin
               state_in     = ST_READOUT;
               req_stall_in = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         ST_READOUT: begin
            if (cmd.clear) begin
               state_in     = ST_COUNT;
               req_stall_in = 1'b0;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_COUNT;
            req_stall_in = 1'b0;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COUNT;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/tsc_datapath.sv]
// tsc_datapath: byte classifier, saturating counters and the letter
// histogram with its shift-out readout. Depends on tsc_pkg.
`default_nettype none

module tsc_datapath
   import tsc_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tsc_cmd_type            cmd,
   input  wire logic [BYTE_BITS-1:0]   text_byte,
   output tsc_status_type              status,
   output logic [LETTER_BITS-1:0]      letter_index,
   output logic [FIELD_BITS-1:0]       letter_count,
   output logic [FIELD_BITS-1:0]       sentence_count,
   output logic [FIELD_BITS-1:0]       word_count,
   output logic [FIELD_BITS-1:0]       upper_count,
   output logic [FIELD_BITS-1:0]       lower_count,
   output logic                        last_of_run
);

   localparam int WIDE_BITS = COUNT_BITS + FIELD_BITS;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
   endfunction

   // low field bits of a count, zero-extended when the counter is narrower
   function automatic logic [FIELD_BITS-1:0] to_field(input logic [COUNT_BITS-1:0] v);
      logic [WIDE_BITS-1:0] wide;
      wide     = {{FIELD_BITS{1'b0}}, v};
      to_field = wide[FIELD_BITS-1:0];
   endfunction

   logic [COUNT_BITS-1:0]  hist_ff [NUM_LETTERS];
   logic [COUNT_BITS-1:0]  hist_in [NUM_LETTERS];
   logic [COUNT_BITS-1:0]  sentences_ff, sentences_in;
   logic [COUNT_BITS-1:0]  spaces_ff, spaces_in;
   logic [COUNT_BITS-1:0]  uppers_ff, uppers_in;
   logic [COUNT_BITS-1:0]  lowers_ff, lowers_in;
   logic [LETTER_BITS-1:0] index_ff, index_in;

   logic                   is_sentence;
   logic                   is_space;
   logic                   is_upper;
   logic                   is_lower;
   logic [BYTE_BITS-1:0]   letter_offset;
   logic [LETTER_BITS-1:0] letter_sel;

   always_comb begin
      is_sentence = (text_byte == BYTE_PERIOD) || (text_byte == BYTE_EXCLAIM)
                    || (text_byte == BYTE_QUESTION);
      is_space    = (text_byte == BYTE_SPACE);
      is_upper    = (text_byte >= BYTE_UPPER_A) && (text_byte <= BYTE_UPPER_Z);
      is_lower    = (text_byte >= BYTE_LOWER_A) && (text_byte <= BYTE_LOWER_Z);
      letter_offset = is_upper ? (text_byte - BYTE_UPPER_A) : (text_byte - BYTE_LOWER_A);
      letter_sel    = letter_offset[LETTER_BITS-1:0];
   end

   always_comb begin
      sentences_in = sentences_ff;
      spaces_in    = spaces_ff;
      uppers_in    = uppers_ff;
      lowers_in    = lowers_ff;
      index_in     = index_ff;
      for (int k = 0; k < NUM_LETTERS; k++) begin
         hist_in[k] = hist_ff[k];
      end

      if (cmd.count) begin
         if (is_sentence) sentences_in = sat_inc(sentences_ff);
         if (is_space)    spaces_in    = sat_inc(spaces_ff);
         if (is_upper)    uppers_in    = sat_inc(uppers_ff);
         if (is_lower)    lowers_in    = sat_inc(lowers_ff);
         for (int k = 0; k < NUM_LETTERS; k++) begin
            if ((is_upper || is_lower) && (letter_sel == LETTER_BITS'(k))) begin
               hist_in[k] = sat_inc(hist_ff[k]);
            end
         end
      end

      // advance the readout: the next letter moves to the head
      if (cmd.shift) begin
         for (int k = 0; k < NUM_LETTERS - 1; k++) begin
            hist_in[k] = hist_ff[k + 1];
         end
         hist_in[NUM_LETTERS-1] = '0;
         index_in = index_ff + LETTER_BITS'(1);
      end

      if (cmd.clear) begin
         sentences_in = '0;
         spaces_in    = '0;
         uppers_in    = '0;
         lowers_in    = '0;
         index_in     = '0;
         for (int k = 0; k < NUM_LETTERS; k++) begin
            hist_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentences_ff <= '0;
         spaces_ff    <= '0;
         uppers_ff    <= '0;
         lowers_ff    <= '0;
         index_ff     <= '0;
         for (int k = 0; k < NUM_LETTERS; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         sentences_ff <= sentences_in;
         spaces_ff    <= spaces_in;
         uppers_ff    <= uppers_in;
         lowers_ff    <= lowers_in;
         index_ff     <= index_in;
         for (int k = 0; k < NUM_LETTERS; k++) begin
            hist_ff[k] <= hist_in[k];
         end
      end
   end

   always_comb begin
      status.last_letter = (index_ff == LAST_LETTER);
      letter_index       = index_ff;
      letter_count       = to_field(hist_ff[0]);
      sentence_count     = to_field(sentences_ff);
      word_count         = to_field(sat_inc(spaces_ff));
      upper_count        = to_field(uppers_ff);
      lower_count        = to_field(lowers_ff);
      last_of_run        = (index_ff == LAST_LETTER);
   end

endmodule

`default_nettype wire

[hw/rtl/text_statistics_counter.sv]
// text_statistics_counter: top level, joins the controller and datapath.
// Depends on tsc_pkg, tsc_ctrl and tsc_datapath.
`default_nettype none

// Counts sentence marks, spaces, upper- and lower-case letters and a
// case-folded a..z histogram over one text, one byte per beat. While
// counting, a byte is taken every cycle. The byte flagged end_of_text is
// counted and then starts a readout of 26 result beats, a to z, one per
// cycle that rsp_stall allows; the histogram shifts toward its head each
// beat, and req_stall stays high for the whole readout. After the z beat
// all counts are zero and input resumes on the next cycle. Counts
// saturate at their maximum; reset clears everything at once, with no
// clearing pass.
module text_statistics_counter
   import tsc_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_BITS-1:0]   req_text_byte,
   input  wire logic                   req_end_of_text,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [LETTER_BITS-1:0]      rsp_letter_index,
   output logic [FIELD_BITS-1:0]       rsp_letter_count,
   output logic [FIELD_BITS-1:0]       rsp_sentence_count,
   output logic [FIELD_BITS-1:0]       rsp_word_count,
   output logic [FIELD_BITS-1:0]       rsp_upper_count,
   output logic [FIELD_BITS-1:0]       rsp_lower_count,
   output logic                        rsp_last_of_run
);

   tsc_cmd_type    cmd;
   tsc_status_type status;

   tsc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_end_of_text (req_end_of_text),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid)
   );

   tsc_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .text_byte      (req_text_byte),
      .status         (status),
      .letter_index   (rsp_letter_index),
      .letter_count   (rsp_letter_count),
      .sentence_count (rsp_sentence_count),
      .word_count     (rsp_word_count),
      .upper_count    (rsp_upper_count),
      .lower_count    (rsp_lower_count),
      .last_of_run    (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   a_readout_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result beat offered while input is open");

   a_readout_starts_at_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_text)
      |=> (rsp_valid && rsp_letter_index == '0))
      else $error("end of text did not start readout at letter a");

   a_readout_ends_after_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_run) |=> (!rsp_valid && !req_stall))
      else $error("readout did not end after letter z");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_letter_index <= LAST_LETTER))
      else $error("letter index beyond z");
`endif

endmodule

`default_nettype wire
